@@ hdl/atpc_pkg.sv @@
package atpc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int OFFSET_W = 14;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [31:0] CHECKER_EVEN = 32'h5555_5555;
	localparam logic [31:0] CHECKER_ODD = 32'haaaa_aaaa;

	typedef enum logic [2:0] {
		MODE_FULL_PLUS = 3'd0,
		MODE_FULL_MINUS = 3'd1,
		MODE_MIDSCALE = 3'd2,
		MODE_CHECKER = 3'd3,
		MODE_ONE_ZERO = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_TEST_MODE = 2'd0,
		REG_CONVERTER_BITS = 2'd1,
		REG_PATTERN_INVERTED = 2'd2
	} reg_idx_t;

	localparam logic [2:0] TEST_MODE_RESET = 3'd0;
	localparam logic [4:0] CONVERTER_BITS_RESET = 5'd14;

	typedef struct packed {
		logic [2:0] test_mode;
		logic [4:0] converter_bits;
		logic pattern_inverted;
	} cfg_t;

endpackage

@@ hdl/atpc_cfg.sv @@
module atpc_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [atpc_pkg::ADDR_W-1:0] paddr,
	input  logic [atpc_pkg::DATA_W-1:0] pwdata,
	output logic [atpc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output atpc_pkg::cfg_t cfg
);

	atpc_pkg::cfg_t cfg_q;
	atpc_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = atpc_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.test_mode <= atpc_pkg::TEST_MODE_RESET;
			cfg_q.converter_bits <= atpc_pkg::CONVERTER_BITS_RESET;
			cfg_q.pattern_inverted <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				atpc_pkg::REG_TEST_MODE: begin
					cfg_q.test_mode <= pwdata[2:0];
				end
				atpc_pkg::REG_CONVERTER_BITS: begin
					cfg_q.converter_bits <= pwdata[4:0];
				end
				atpc_pkg::REG_PATTERN_INVERTED: begin
					cfg_q.pattern_inverted <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			atpc_pkg::REG_TEST_MODE: begin
				prdata[2:0] = cfg_q.test_mode;
			end
			atpc_pkg::REG_CONVERTER_BITS: begin
				prdata[4:0] = cfg_q.converter_bits;
			end
			atpc_pkg::REG_PATTERN_INVERTED: begin
				prdata[0] = cfg_q.pattern_inverted;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

@@ hdl/atpc_pattern.sv @@
module atpc_pattern #(
	parameter int MAX_SAMPLE_BITS = 16
) (
	input  atpc_pkg::cfg_t cfg,
	output logic [MAX_SAMPLE_BITS-1:0] word_first,
	output logic [MAX_SAMPLE_BITS-1:0] word_second
);

	localparam logic [5:0] MaxBits = 6'(MAX_SAMPLE_BITS);

	logic [5:0] bits_req;
	logic [5:0] bits;
	logic [MAX_SAMPLE_BITS-1:0] mask;
	logic [MAX_SAMPLE_BITS-1:0] a;
	logic [MAX_SAMPLE_BITS-1:0] b;
	atpc_pkg::mode_t mode;

	assign bits_req = {1'b0, cfg.converter_bits};
	assign mode = atpc_pkg::mode_t'(cfg.test_mode);

	always_comb begin
		if (bits_req == 6'd0) begin
			bits = 6'd1;
		end else if (bits_req > MaxBits) begin
			bits = MaxBits;
		end else begin
			bits = bits_req;
		end
		mask = ~({MAX_SAMPLE_BITS{1'b1}} << bits);
		case (mode)
			atpc_pkg::MODE_FULL_MINUS: begin
				a = '0;
				b = '0;
			end
			atpc_pkg::MODE_MIDSCALE: begin
				a = MAX_SAMPLE_BITS'(1) << (bits - 6'd1);
				b = a;
			end
			atpc_pkg::MODE_CHECKER: begin
				a = MAX_SAMPLE_BITS'(atpc_pkg::CHECKER_EVEN) & mask;
				b = MAX_SAMPLE_BITS'(atpc_pkg::CHECKER_ODD) & mask;
			end
			atpc_pkg::MODE_ONE_ZERO: begin
				a = mask;
				b = '0;
			end
			default: begin
				a = mask;
				b = mask;
			end
		endcase
		if (cfg.pattern_inverted) begin
			word_first = ~a & mask;
			word_second = ~b & mask;
		end else begin
			word_first = a;
			word_second = b;
		end
	end

endmodule

@@ hdl/atpc_check.sv @@
module atpc_check #(
	parameter int MAX_TRACE_SAMPLES = 8192,
	parameter int MAX_SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [MAX_SAMPLE_BITS-1:0] word_first,
	input  logic [MAX_SAMPLE_BITS-1:0] word_second,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [atpc_pkg::SAMPLE_W-1:0] sample_even,
	input  logic [atpc_pkg::SAMPLE_W-1:0] sample_odd,
	input  logic last_pair,
	output logic result_valid,
	input  logic result_stall,
	output logic pair_pass,
	output logic trace_done,
	output logic trace_failed,
	output logic [atpc_pkg::OFFSET_W-1:0] failure_offset
);

	localparam int PW = $clog2(MAX_TRACE_SAMPLES + 1);
	localparam int CW = (MAX_SAMPLE_BITS > atpc_pkg::SAMPLE_W) ?
		MAX_SAMPLE_BITS : atpc_pkg::SAMPLE_W;
	localparam logic [PW:0] MaxPos = (PW + 1)'(MAX_TRACE_SAMPLES);

	logic valid_s1;
	logic [atpc_pkg::SAMPLE_W-1:0] even_s1;
	logic [atpc_pkg::SAMPLE_W-1:0] odd_s1;
	logic last_s1;

	logic valid_s2;
	logic pass_s2;
	logic done_s2;
	logic failed_s2;
	logic [PW-1:0] offset_s2;

	logic [PW-1:0] pos_q;
	logic failed_q;
	logic [PW-1:0] first_q;

	logic adv1;
	logic adv2;
	logic [CW-1:0] ev;
	logic [CW-1:0] od;
	logic [CW-1:0] w1;
	logic [CW-1:0] w2;
	logic pass;
	logic failed_n;
	logic [PW-1:0] first_n;
	logic [PW:0] pos_sum;
	logic [PW-1:0] next_pos;
	logic [PW-1:0] offset_n;
	logic [PW+atpc_pkg::OFFSET_W-1:0] offset_ext;

	assign adv2 = !valid_s2 || !result_stall;
	assign adv1 = !valid_s1 || adv2;
	assign sample_stall = !adv1;

	assign ev = CW'(even_s1);
	assign od = CW'(odd_s1);
	assign w1 = CW'(word_first);
	assign w2 = CW'(word_second);

	always_comb begin
		pass = (ev == w1) && (od == w2);
		if (!pass && (w1 != w2)) begin
			pass = (ev == w1) || (ev == w2) || (od == w1) || (od == w2);
		end
		failed_n = failed_q || !pass;
		first_n = (!pass && !failed_q) ? pos_q : first_q;
		pos_sum = {1'b0, pos_q} + (PW + 1)'(2);
		if (pos_sum > MaxPos) begin
			next_pos = MaxPos[PW-1:0];
		end else begin
			next_pos = pos_sum[PW-1:0];
		end
		if (failed_n) begin
			offset_n = first_n;
		end else if (last_s1) begin
			offset_n = next_pos;
		end else begin
			offset_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q <= '0;
			failed_q <= 1'b0;
			first_q <= '0;
		end else begin
			if (adv1) begin
				valid_s1 <= sample_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv2 && valid_s1) begin
				if (last_s1) begin
					pos_q <= '0;
					failed_q <= 1'b0;
					first_q <= '0;
				end else begin
					pos_q <= next_pos;
					failed_q <= failed_n;
					first_q <= first_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && sample_valid) begin
			even_s1 <= sample_even;
			odd_s1 <= sample_odd;
			last_s1 <= last_pair;
		end
		if (adv2 && valid_s1) begin
			pass_s2 <= pass;
			done_s2 <= last_s1;
			failed_s2 <= failed_n;
			offset_s2 <= offset_n;
		end
	end

	assign offset_ext = (PW + atpc_pkg::OFFSET_W)'(offset_s2);

	assign result_valid = valid_s2;
	assign pair_pass = pass_s2;
	assign trace_done = done_s2;
	assign trace_failed = failed_s2;
	assign failure_offset = offset_ext[atpc_pkg::OFFSET_W-1:0];

endmodule

@@ hdl/adc_test_pattern_checker.sv @@
// Converter test pattern checker.
// Configuration: APB-style port, registers test_mode at 0x0, converter_bits at
// 0x4, pattern_inverted at 0x8; pready is always high, reads return the value.
// Input channel: sample_valid/sample_stall carry one item, a pair of
// consecutive samples plus last_pair. Result channel: result_valid/
// result_stall carry pair_pass, trace_done, trace_failed and failure_offset.
// An item is taken on an edge with valid high and stall low.
// An item goes to the input register, then to the result register, whose
// load raises result_valid and waits while a waiting result is stalled.
// Throughput: one item per cycle while result_stall is low; the compare and
// the trace state update sit between the two registers.
// When result_stall is high with a result waiting, the result register holds;
// an empty input register still takes one more item, and once both registers
// are full sample_stall follows result_stall in the same cycle.
// Reset clears both pipeline valids, the trace position and first-failure
// state, and loads the configuration defaults (full scale plus, 14 bits,
// not inverted). After a last_pair item the trace state returns to zero.
module adc_test_pattern_checker #(
	parameter int MAX_TRACE_SAMPLES = 8192,
	parameter int MAX_SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [atpc_pkg::ADDR_W-1:0] paddr,
	input  logic [atpc_pkg::DATA_W-1:0] pwdata,
	output logic [atpc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [atpc_pkg::SAMPLE_W-1:0] sample_even,
	input  logic [atpc_pkg::SAMPLE_W-1:0] sample_odd,
	input  logic last_pair,
	output logic result_valid,
	input  logic result_stall,
	output logic pair_pass,
	output logic trace_done,
	output logic trace_failed,
	output logic [atpc_pkg::OFFSET_W-1:0] failure_offset
);

	atpc_pkg::cfg_t cfg;
	logic [MAX_SAMPLE_BITS-1:0] word_first;
	logic [MAX_SAMPLE_BITS-1:0] word_second;

	atpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	atpc_pattern #(
		.MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
	) u_pattern (
		.cfg(cfg),
		.word_first(word_first),
		.word_second(word_second)
	);

	atpc_check #(
		.MAX_TRACE_SAMPLES(MAX_TRACE_SAMPLES),
		.MAX_SAMPLE_BITS(MAX_SAMPLE_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.word_first(word_first),
		.word_second(word_second),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_even(sample_even),
		.sample_odd(sample_odd),
		.last_pair(last_pair),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pair_pass(pair_pass),
		.trace_done(trace_done),
		.trace_failed(trace_failed),
		.failure_offset(failure_offset)
	);

endmodule
